// ----- rtl/bums_pkg.sv -----
package bums_pkg;

   localparam int KEY_W = 32;

   typedef logic [KEY_W-1:0] key_word_type;

endpackage

// ----- rtl/bums_req_if.sv -----
interface bums_req_if
   import bums_pkg::*;
();
   logic         valid;
   logic         ready;
   key_word_type key;
   logic         last_key;

   modport source (output valid, output key, output last_key, input ready);
   modport sink   (input valid, input key, input last_key, output ready);
endinterface

// ----- rtl/bums_rsp_if.sv -----
interface bums_rsp_if
   import bums_pkg::*;
();
   logic         valid;
   logic         ready;
   key_word_type sorted_key;
   logic         final_result;
   logic         overflow;

   modport source (output valid, output sorted_key, output final_result, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_key, input final_result, input overflow,
                   output ready);
endinterface

// ----- rtl/bums_cell.sv -----
module bums_cell
   import bums_pkg::*;
#(
   parameter int KEY_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic                in_valid,
   input  logic [KEY_BITS-1:0] in_key,
   input  logic                right_valid,
   input  logic [KEY_BITS-1:0] right_key,
   output logic                valid,
   output logic [KEY_BITS-1:0] key,
   output logic                carry_valid,
   output logic [KEY_BITS-1:0] carry_key
);

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                carry_valid_ff, carry_valid_in;
   logic [KEY_BITS-1:0] carry_key_ff, carry_key_in;

   // on insert keep the smaller key and hand the larger one down the row; on shift take the right neighbour's entry
   always_comb begin
      valid_in       = valid_ff;
      key_in         = key_ff;
      carry_valid_in = 1'b0;
      carry_key_in   = carry_key_ff;
      if (shift) begin
         valid_in = right_valid;
         key_in   = right_key;
      end else if (in_valid) begin
         if (!valid_ff) begin
            valid_in = 1'b1;
            key_in   = in_key;
         end else if (in_key < key_ff) begin
            key_in         = in_key;
            carry_key_in   = key_ff;
            carry_valid_in = 1'b1;
         end else begin
            carry_key_in   = in_key;
            carry_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         carry_valid_ff <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         carry_valid_ff <= carry_valid_in;
      end
      key_ff       <= key_in;
      carry_key_ff <= carry_key_in;
   end

   assign valid       = valid_ff;
   assign key         = key_ff;
   assign carry_valid = carry_valid_ff;
   assign carry_key   = carry_key_ff;

endmodule

// ----- rtl/bottom_up_merge_sort_unit.sv -----
// after the last request of a set, the block waits in SETTLE for the row of cells to
// settle, then gives one sorted key per cycle while the output is taken
// one request per cycle while loading; no new set is taken until the last key of the
// set has been emitted; keys beyond CAPACITY are dropped and flagged as overflow
// reset: synchronous, clears the cells, the key count, the overflow flag and the output valid
module bottom_up_merge_sort_unit
   import bums_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int KEY_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   bums_req_if.sink   req_if,
   bums_rsp_if.source rsp_if
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      LOAD,
      SETTLE,
      EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   timer_ff, timer_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   key_word_type       rsp_key_ff, rsp_key_in;
   logic               rsp_final_ff, rsp_final_in;
   logic               rsp_overflow_ff, rsp_overflow_in;

   logic               accept;
   logic               push;
   logic               shift;
   logic               take;
   logic [KEY_BITS-1:0] push_key;

   logic                cell_valid [CAPACITY];
   logic [KEY_BITS-1:0] cell_key   [CAPACITY];
   logic                carry_valid[CAPACITY];
   logic [KEY_BITS-1:0] carry_key  [CAPACITY];

   assign req_if.ready = (state_ff == LOAD);
   assign accept       = req_if.valid && req_if.ready;
   assign push         = accept && (count_ff != CNT_W'(CAPACITY));
   assign push_key     = KEY_BITS'(req_if.key);
   assign take         = !rsp_valid_ff || rsp_if.ready;
   assign shift        = (state_ff == EMIT) && take;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                left_valid;
      logic [KEY_BITS-1:0] left_key;
      logic                nbr_valid;
      logic [KEY_BITS-1:0] nbr_key;

      if (i == 0) begin : g_head
         assign left_valid = push;
         assign left_key   = push_key;
      end else begin : g_body
         assign left_valid = carry_valid[i-1];
         assign left_key   = carry_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign nbr_valid = 1'b0;
         assign nbr_key   = '0;
      end else begin : g_inner
         assign nbr_valid = cell_valid[i+1];
         assign nbr_key   = cell_key[i+1];
      end

      bums_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (shift),
         .in_valid    (left_valid),
         .in_key      (left_key),
         .right_valid (nbr_valid),
         .right_key   (nbr_key),
         .valid       (cell_valid[i]),
         .key         (cell_key[i]),
         .carry_valid (carry_valid[i]),
         .carry_key   (carry_key[i])
      );
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      timer_in        = timer_ff;
      dropped_in      = dropped_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_key_in      = rsp_key_ff;
      rsp_final_in    = rsp_final_ff;
      rsp_overflow_in = rsp_overflow_ff;
      case (state_ff)
         LOAD: begin
            if (accept) begin
               if (push) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_if.last_key) begin
                  state_in = SETTLE;
                  timer_in = CNT_W'(CAPACITY);
               end
            end
         end
         SETTLE: begin
            timer_in = timer_ff - CNT_W'(1);
            if (timer_ff == '0) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (take) begin
               rsp_valid_in    = 1'b1;
               rsp_key_in      = KEY_W'(cell_key[0]);
               rsp_final_in    = (count_ff == CNT_W'(1));
               rsp_overflow_in = dropped_ff;
               count_in        = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in   = LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         count_ff     <= '0;
         timer_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         timer_ff     <= timer_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_key_ff      <= rsp_key_in;
      rsp_final_ff    <= rsp_final_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sorted_key   = rsp_key_ff;
   assign rsp_if.final_result = rsp_final_ff;
   assign rsp_if.overflow     = rsp_overflow_ff;

endmodule
